// File: design/ptu_pkg.sv
`default_nettype none

package ptu_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned MODE_W    = 5;
   localparam int unsigned REG_IDX_W = 4;
   localparam int unsigned BANK_N    = 5;
   localparam int unsigned BANK_W    = $clog2(BANK_N);

   localparam logic [MODE_W-1:0] MODE_USER = 5'h10;
   localparam logic [MODE_W-1:0] MODE_FIQ  = 5'h11;
   localparam logic [MODE_W-1:0] MODE_IRQ  = 5'h12;
   localparam logic [MODE_W-1:0] MODE_SVC  = 5'h13;
   localparam logic [MODE_W-1:0] MODE_ABT  = 5'h17;
   localparam logic [MODE_W-1:0] MODE_UND  = 5'h1B;

   localparam logic [BANK_W-1:0] BANK_FIQ = 3'd0;
   localparam logic [BANK_W-1:0] BANK_IRQ = 3'd1;
   localparam logic [BANK_W-1:0] BANK_SVC = 3'd2;
   localparam logic [BANK_W-1:0] BANK_ABT = 3'd3;
   localparam logic [BANK_W-1:0] BANK_UND = 3'd4;

   localparam logic [WORD_W-1:0] CPSR_RESET = 32'h0000_00D3;
   localparam logic [WORD_W-1:0] BYTE0_MASK = 32'h0000_00FF;
   localparam logic [WORD_W-1:0] BYTE1_MASK = 32'h0000_FF00;
   localparam logic [WORD_W-1:0] BYTE2_MASK = 32'h00FF_0000;
   localparam logic [WORD_W-1:0] FLAG_MASK  = 32'hFF00_0000;

   // instruction bit positions
   localparam int unsigned BIT_IMM       = 25;
   localparam int unsigned BIT_SPSR      = 22;
   localparam int unsigned BIT_FIELD0    = 16;
   localparam logic        OP_MRS        = 1'b0;
   localparam logic        OP_MSR        = 1'b1;

   typedef struct packed {
      logic              op;
      logic [WORD_W-1:0] instr;
      logic [WORD_W-1:0] reg_value;
   } req_type;

   typedef struct packed {
      logic                 reg_write;
      logic [REG_IDX_W-1:0] dest_reg;
      logic [WORD_W-1:0]    write_data;
      logic                 mode_changed;
      logic [MODE_W-1:0]    new_mode;
      logic [WORD_W-1:0]    cpsr_out;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] mask;
   } operand_type;

   typedef struct packed {
      logic              hit;
      logic [BANK_W-1:0] idx;
   } bank_type;

   function automatic bank_type bank_of(input logic [MODE_W-1:0] mode);
      bank_type b;
      b.hit = 1'b1;
      b.idx = BANK_FIQ;
      case (mode)
         MODE_FIQ: b.idx = BANK_FIQ;
         MODE_IRQ: b.idx = BANK_IRQ;
         MODE_SVC: b.idx = BANK_SVC;
         MODE_ABT: b.idx = BANK_ABT;
         MODE_UND: b.idx = BANK_UND;
         default:  b.hit = 1'b0;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// File: design/ptu_stream_if.sv
`default_nettype none

interface ptu_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/psr_transfer_unit_top.sv
`default_nettype none

// PSR transfer unit: executes MRS and MSR words against a CPSR and five banked
// SPSRs (fiq, irq, svc, abt, und). A word passes an input register and then a
// result register, from which its result is presented, and one word is taken
// every cycle as long as the response side keeps up; the CPSR/SPSR
// update happens as a word moves into the result register, so each word sees
// the state left by the one before it. req_chan.ready follows rsp_chan.ready
// combinationally when both registers are full. After reset the CPSR is 0xD3
// (svc mode, irq and fiq masked) and all SPSRs are zero.
module psr_transfer_unit_top
   import ptu_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   ptu_stream_if.sink    req_chan,
   ptu_stream_if.source  rsp_chan
);

   logic        in_valid_ff;
   req_type     in_data_ff;
   logic        out_valid_ff;
   rsp_type     out_data_ff;

   logic        advance;
   operand_type operand;
   rsp_type     result;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   ptu_operand u_operand (
      .instr     (in_data_ff.instr),
      .reg_value (in_data_ff.reg_value),
      .operand   (operand)
   );

   ptu_psr_file u_psr_file (
      .clock   (clock),
      .reset   (reset),
      .exec    (advance),
      .item    (in_data_ff),
      .operand (operand),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff <= req_chan.payload;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

endmodule

`default_nettype wire

// File: design/ptu_operand.sv
`default_nettype none

module ptu_operand
   import ptu_pkg::*;
(
   input  wire logic [WORD_W-1:0] instr,
   input  wire logic [WORD_W-1:0] reg_value,
   output operand_type            operand
);

   logic [2*WORD_W-1:0] imm_pair;
   logic [2*WORD_W-1:0] imm_rot;
   logic [4:0]          rot_amt;

   // rotate right of a doubled word: low half holds the wrapped bits
   assign imm_pair = {24'b0, instr[7:0], 24'b0, instr[7:0]};
   assign rot_amt  = {instr[11:8], 1'b0};
   assign imm_rot  = imm_pair >> rot_amt;

   always_comb begin
      operand.value = instr[BIT_IMM] ? imm_rot[WORD_W-1:0] : reg_value;
      operand.mask  = '0;
      if (instr[BIT_FIELD0]) begin
         operand.mask = operand.mask | BYTE0_MASK;
      end
      if (instr[BIT_FIELD0+1]) begin
         operand.mask = operand.mask | BYTE1_MASK;
      end
      if (instr[BIT_FIELD0+2]) begin
         operand.mask = operand.mask | BYTE2_MASK;
      end
      if (instr[BIT_FIELD0+3]) begin
         operand.mask = operand.mask | FLAG_MASK;
      end
   end

endmodule

`default_nettype wire

// File: design/ptu_psr_file.sv
`default_nettype none

module ptu_psr_file
   import ptu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        exec,
   input  req_type          item,
   input  operand_type      operand,
   output rsp_type          result
);

   logic [WORD_W-1:0] cpsr_ff;
   logic [WORD_W-1:0] cpsr_in;
   logic [WORD_W-1:0] spsr_ff [BANK_N];
   logic [WORD_W-1:0] spsr_in;

   logic [MODE_W-1:0] cur_mode;
   bank_type          bank;
   logic              use_spsr;
   logic              write_cpsr;
   logic              write_spsr;
   logic [WORD_W-1:0] spsr_cur;
   logic [WORD_W-1:0] cpsr_mask;
   logic [WORD_W-1:0] cpsr_merge;

   assign cur_mode   = cpsr_ff[MODE_W-1:0];
   assign bank       = bank_of(cur_mode);
   assign use_spsr   = item.instr[BIT_SPSR];
   assign write_cpsr = (item.op == OP_MSR) && !use_spsr;
   assign write_spsr = (item.op == OP_MSR) && use_spsr && bank.hit;

   // modes without a bank see the cpsr in place of an spsr
   assign spsr_cur   = bank.hit ? spsr_ff[bank.idx] : cpsr_ff;

   // user mode may only touch the flag byte
   assign cpsr_mask  = (cur_mode == MODE_USER) ? (operand.mask & FLAG_MASK) : operand.mask;
   assign cpsr_merge = (cpsr_ff & ~cpsr_mask) | (operand.value & cpsr_mask);
   assign spsr_in    = (spsr_cur & ~operand.mask) | (operand.value & operand.mask);
   assign cpsr_in    = write_cpsr ? cpsr_merge : cpsr_ff;

   always_comb begin
      result.reg_write    = (item.op == OP_MRS);
      result.dest_reg     = (item.op == OP_MRS) ? item.instr[15:12] : '0;
      result.write_data   = '0;
      if (item.op == OP_MRS) begin
         result.write_data = use_spsr ? spsr_cur : cpsr_ff;
      end
      result.mode_changed = write_cpsr && (cpsr_merge[MODE_W-1:0] != cur_mode);
      result.new_mode     = cpsr_in[MODE_W-1:0];
      result.cpsr_out     = cpsr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpsr_ff <= CPSR_RESET;
         for (int i = 0; i < BANK_N; i++) begin
            spsr_ff[i] <= '0;
         end
      end else if (exec) begin
         cpsr_ff <= cpsr_in;
         if (write_spsr) begin
            spsr_ff[bank.idx] <= spsr_in;
         end
      end
   end

   a_idle_holds_cpsr: assert property (@(posedge clock) disable iff (reset)
      !exec |=> $stable(cpsr_ff))
      else $error("cpsr changed without an executed word");

   a_mrs_holds_cpsr: assert property (@(posedge clock) disable iff (reset)
      exec && (item.op == OP_MRS) |=> $stable(cpsr_ff))
      else $error("mrs changed the cpsr");

   a_user_flags_only: assert property (@(posedge clock) disable iff (reset)
      exec && write_cpsr && (cur_mode == MODE_USER)
      |=> cpsr_ff[23:0] == $past(cpsr_ff[23:0]))
      else $error("user mode write reached control bits");

   a_mode_change_seen: assert property (@(posedge clock) disable iff (reset)
      exec && result.mode_changed
      |=> cpsr_ff[MODE_W-1:0] != $past(cpsr_ff[MODE_W-1:0]))
      else $error("reported mode change did not land");

endmodule

`default_nettype wire
